@@ rtl/sacl_pkg.sv @@
`timescale 1ns / 1ps
package sacl_pkg;
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_STORE  = 2'd1;
    localparam logic [1:0] KIND_MODIFY = 2'd2;
    localparam logic [1:0] KIND_IGNORE = 2'd3;
    localparam logic [1:0] REG_SET_BITS    = 2'd0;
    localparam logic [1:0] REG_WAYS        = 2'd1;
    localparam logic [1:0] REG_OFFSET_BITS = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] tag;
        logic [11:0] set;
    } sacl_req_t;
endpackage

@@ rtl/sacl_front.sv @@
`timescale 1ns / 1ps
module sacl_front #(
    parameter int MAX_SET_BITS = 8,
    parameter int ADDR_BITS    = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [3:0]           set_bits,
    input  logic [4:0]           offset_bits,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_access_kind,
    input  logic [ADDR_BITS-1:0] s_address,
    output logic                 q_valid,
    input  logic                 q_ready,
    output sacl_pkg::sacl_req_t  q_req
);
    import sacl_pkg::*;
    localparam int QD = 2;

    sacl_req_t  q_mem_reg [QD];
    logic [0:0] wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [3:0] sb;
    logic [6:0] tshift;
    logic [ADDR_BITS-1:0] set_full, tag_full;
    sacl_req_t  req;
    logic push, pop;

    always_comb begin
        sb = (set_bits > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : set_bits;
        tshift = 7'(offset_bits) + 7'(sb);
        set_full = (7'(offset_bits) >= 7'(ADDR_BITS)) ? '0 : (s_address >> offset_bits);
        tag_full = (tshift >= 7'(ADDR_BITS)) ? '0 : (s_address >> tshift);
        req.kind = s_access_kind;
        req.tag  = 64'(tag_full);
        req.set  = 12'(set_full & ((ADDR_BITS'(1) << sb) - ADDR_BITS'(1)));
    end

    assign s_ready = (cnt_reg != 2'(QD));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_req   = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
        if (push) q_mem_reg[wr_ptr_reg] <= req;
    end
endmodule

@@ rtl/sacl_back.sv @@
`timescale 1ns / 1ps
module sacl_back #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [3:0]          ways_in_use,
    input  logic                q_valid,
    output logic                q_ready,
    input  sacl_pkg::sacl_req_t q_req,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_first_hit,
    output logic                m_first_miss,
    output logic                m_evicted,
    output logic                m_second_hit,
    output logic [31:0]         m_hit_count,
    output logic [31:0]         m_miss_count,
    output logic [31:0]         m_eviction_count,
    output logic                busy
);
    import sacl_pkg::*;
    localparam int NSETS = 1 << MAX_SET_BITS;
    localparam int SW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam logic [AW-1:0] AGE_MAX = AW'(MAX_WAYS - 1);

    typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_UPDATE, ST_OUT} state_t;
    typedef logic [MAX_WAYS-1:0][63:0]   tag_row_t;
    typedef logic [MAX_WAYS-1:0][AW-1:0] age_row_t;

    tag_row_t tag_mem [NSETS];
    age_row_t age_mem [NSETS];
    logic [MAX_WAYS-1:0] valid_mem [NSETS];

    state_t state_reg;
    logic [SW-1:0] clr_reg;
    sacl_req_t req_reg;
    logic second_reg;
    tag_row_t tag_row_reg;
    age_row_t age_row_reg;
    logic [MAX_WAYS-1:0] vrow_reg;
    logic [31:0] hit_reg, miss_reg, evict_reg;
    logic h1_reg, m1_reg, ev_reg, h2_reg;

    logic [SW-1:0] set_idx;
    logic [4:0] ways;
    logic hit, found_inv, hit_found;
    logic [WW-1:0] pick, hit_way, inv_way, old_way;
    logic [AW-1:0] best, lim;
    logic [AW:0]   lim_ext;
    age_row_t age_new;

    assign set_idx = SW'(req_reg.set);

    always_comb begin
        ways = (ways_in_use == 4'd0) ? 5'd1 :
               ((5'(ways_in_use) > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : 5'(ways_in_use));
        hit_found = 1'b0; hit_way = '0;
        found_inv = 1'b0; inv_way = '0;
        best = '0; old_way = '0;
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (5'(j) < ways) begin
                if (!hit_found && vrow_reg[j] && tag_row_reg[j] == req_reg.tag) begin
                    hit_found = 1'b1; hit_way = WW'(j);
                end
                if (!found_inv && !vrow_reg[j]) begin
                    found_inv = 1'b1; inv_way = WW'(j);
                end
                if (age_row_reg[j] > best) begin
                    best = age_row_reg[j]; old_way = WW'(j);
                end
            end
        end
        hit  = hit_found;
        pick = hit ? hit_way : (found_inv ? inv_way : old_way);
        lim_ext = hit ? {1'b0, age_row_reg[hit_way]} : (AW+1)'(MAX_WAYS);
        lim = '0;
        age_new = age_row_reg;
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (5'(j) < ways && WW'(j) != pick && vrow_reg[j]
                && {1'b0, age_row_reg[j]} < lim_ext && age_row_reg[j] < AGE_MAX)
                age_new[j] = age_row_reg[j] + 1'b1;
        end
        age_new[pick] = lim;
    end

    assign q_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign busy    = (state_reg != ST_IDLE);
    assign m_first_hit = h1_reg;
    assign m_first_miss = m1_reg;
    assign m_evicted = ev_reg;
    assign m_second_hit = h2_reg;
    assign m_hit_count = hit_reg;
    assign m_miss_count = miss_reg;
    assign m_eviction_count = evict_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            valid_mem[clr_reg] <= '0;
            age_mem[clr_reg]   <= '0;
        end
        if (state_reg == ST_READ) begin
            tag_row_reg <= tag_mem[set_idx];
            age_row_reg <= age_mem[set_idx];
            vrow_reg    <= valid_mem[set_idx];
        end
        if (state_reg == ST_UPDATE) begin
            tag_mem[set_idx][pick] <= req_reg.tag;
            age_mem[set_idx] <= age_new;
            valid_mem[set_idx][pick] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            hit_reg <= '0; miss_reg <= '0; evict_reg <= '0;
            h1_reg <= 1'b0; m1_reg <= 1'b0; ev_reg <= 1'b0; h2_reg <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SW'(NSETS - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (q_valid) begin
                        req_reg <= q_req;
                        second_reg <= 1'b0;
                        h1_reg <= 1'b0; m1_reg <= 1'b0; ev_reg <= 1'b0; h2_reg <= 1'b0;
                        state_reg <= (q_req.kind == KIND_IGNORE) ? ST_OUT : ST_READ;
                    end
                end
                ST_READ: state_reg <= ST_UPDATE;
                ST_UPDATE: begin
                    if (hit) begin
                        if (hit_reg != '1) hit_reg <= hit_reg + 32'd1;
                    end else begin
                        if (miss_reg != '1) miss_reg <= miss_reg + 32'd1;
                        if (!found_inv && evict_reg != '1) evict_reg <= evict_reg + 32'd1;
                    end
                    if (second_reg) begin
                        h2_reg <= hit;
                        state_reg <= ST_OUT;
                    end else begin
                        h1_reg <= hit;
                        m1_reg <= !hit;
                        ev_reg <= !hit && !found_inv;
                        if (req_reg.kind == KIND_MODIFY) begin
                            second_reg <= 1'b1;
                            state_reg <= ST_READ;
                        end else begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_OUT: if (m_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/set_assoc_lru_cache_sim.sv @@
`timescale 1ns / 1ps
// Each item passes through a two-entry front queue; the back end then reads and
// updates its set for a load or store, twice for a modify, and sends an ignored
// item straight to the result. The back end takes a new item only once the last result
// is taken, while the front queue can still accept items. Result held until taken.
// Reset: synchronous active low; resets totals and config, then clears valid bits and
// ages one set per cycle over 2**MAX_SET_BITS sets (256 by default), then serves items.
module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_BITS    = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [4:0]           cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_access_kind,
    input  logic [ADDR_BITS-1:0] s_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_first_hit,
    output logic                 m_first_miss,
    output logic                 m_evicted,
    output logic                 m_second_hit,
    output logic [31:0]          m_hit_count,
    output logic [31:0]          m_miss_count,
    output logic [31:0]          m_eviction_count
);
    import sacl_pkg::*;
    logic [3:0] set_bits_reg, ways_reg;
    logic [4:0] offset_bits_reg;
    logic q_valid, q_ready, busy;
    sacl_req_t q_req;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg <= 4'd4;
            ways_reg <= 4'd1;
            offset_bits_reg <= 5'd4;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SET_BITS:    set_bits_reg <= cfg_data[3:0];
                REG_WAYS:        ways_reg <= cfg_data[3:0];
                REG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    sacl_front #(.MAX_SET_BITS(MAX_SET_BITS), .ADDR_BITS(ADDR_BITS)) u_front (
        .aclk, .aresetn, .set_bits(set_bits_reg), .offset_bits(offset_bits_reg),
        .s_valid, .s_ready, .s_access_kind, .s_address, .q_valid, .q_ready, .q_req);

    sacl_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_back (
        .aclk, .aresetn, .ways_in_use(ways_reg), .q_valid, .q_ready, .q_req,
        .m_valid, .m_ready, .m_first_hit, .m_first_miss, .m_evicted, .m_second_hit,
        .m_hit_count, .m_miss_count, .m_eviction_count, .busy);

`ifndef SYNTH
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_first_hit && m_first_miss)) else $error("hit and miss");
    a_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_evicted |-> m_first_miss) else $error("evict without miss");
    a_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_second_hit |-> (m_first_hit || m_first_miss)) else $error("second hit");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> busy) else $error("output while idle");
`endif
endmodule
